/* sv/lcd_window_fill_sequencer_macros.svh */
// Assertion macros used by the sequencer back end.
`ifndef LCD_WINDOW_FILL_SEQUENCER_MACROS_SVH
`define LCD_WINDOW_FILL_SEQUENCER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LWFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define LWFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

/* sv/lwfs_pkg.sv */
// Shared types, codes and constants of the window and fill sequencer.
`timescale 1ns / 1ps

package lwfs_pkg;

	localparam int COORD_W      = 9;
	localparam int BOUND_W      = 16;
	localparam int COLOR_W      = 16;
	localparam int COUNT_W      = 17;
	localparam int REQ_W        = 3;
	localparam int KIND_W       = 2;
	localparam int BYTE_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;
	localparam int S_TDATA_W    = 72;
	localparam int M_TDATA_W    = 48;
	localparam int FIFO_DEPTH_DEF = 4;

	localparam logic [REQ_W-1:0] REQ_FILL  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BEGIN = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PIXEL = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RUN   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_END   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_CMD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET   = 2'd3;

	localparam logic [CFG_DATA_W-1:0] PANEL_WIDTH_RST  = 9'd240;
	localparam logic [CFG_DATA_W-1:0] PANEL_HEIGHT_RST = 9'd320;

	localparam logic [BYTE_W-1:0] CMD_COLUMN_WINDOW = 8'h2A;
	localparam logic [BYTE_W-1:0] CMD_ROW_WINDOW    = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE  = 8'h2C;
	localparam logic [BOUND_W-1:0] LOW_BYTE_MASK    = 16'h00FF;
	localparam logic [COUNT_W-1:0] RUN_MAX          = 17'h1FFFF;

	typedef struct packed {
		logic                rel_first;
		logic                win;
		logic                run;
		logic                rel_last;
		logic [BOUND_W-1:0]  col_first;
		logic [BOUND_W-1:0]  col_final;
		logic [BOUND_W-1:0]  row_first;
		logic [BOUND_W-1:0]  row_final;
		logic [COLOR_W-1:0]  color;
		logic [COUNT_W-1:0]  run_len;
	} job_t;

endpackage

/* sv/lwfs_front.sv */
// Front end: configuration registers, request decode, clipping and job build.
`timescale 1ns / 1ps

module lwfs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lwfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lwfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lwfs_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [lwfs_pkg::REQ_W-1:0]      s_tuser,
	input  logic                           job_full,
	output logic                           job_push,
	output lwfs_pkg::job_t                 job
);
	import lwfs_pkg::*;

	logic [CFG_DATA_W-1:0] panel_width_q;
	logic [CFG_DATA_W-1:0] panel_height_q;
	logic [CFG_DATA_W-1:0] col_offset_q;
	logic [CFG_DATA_W-1:0] row_offset_q;
	logic                  write_open_q;

	logic [COORD_W-1:0]  pos_x, pos_y, size_w, size_h;
	logic [COLOR_W-1:0]  pixel_color;
	logic [COUNT_W-1:0]  pixel_count;
	logic                accept;
	logic                has_result;
	logic                open_nxt;
	logic                fill_ok;
	logic [COORD_W:0]    x_end, y_end;
	logic [COORD_W-1:0]  clip_w, clip_h;
	logic [2*COORD_W-1:0] area;
	logic [COUNT_W-1:0]  area_sat;
	logic [COORD_W-1:0]  win_w, win_h;

	assign pos_x       = s_tdata[8:0];
	assign pos_y       = s_tdata[17:9];
	assign size_w      = s_tdata[26:18];
	assign size_h      = s_tdata[35:27];
	assign pixel_color = s_tdata[51:36];
	assign pixel_count = s_tdata[68:52];

	assign s_tready = !job_full;
	assign accept   = s_tvalid && s_tready;
	assign job_push = accept && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
			col_offset_q   <= '0;
			row_offset_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata;
				CFG_PANEL_HEIGHT: panel_height_q <= cfg_wdata;
				CFG_COL_OFFSET:   col_offset_q   <= cfg_wdata;
				CFG_ROW_OFFSET:   row_offset_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_open_q <= 1'b0;
		end else if (accept) begin
			write_open_q <= open_nxt;
		end
	end

	// clip fills to the panel
	assign x_end  = {1'b0, pos_x} + {1'b0, size_w};
	assign y_end  = {1'b0, pos_y} + {1'b0, size_h};
	assign clip_w = (x_end > {1'b0, panel_width_q})  ? panel_width_q  - pos_x : size_w;
	assign clip_h = (y_end > {1'b0, panel_height_q}) ? panel_height_q - pos_y : size_h;
	assign area   = {{COORD_W{1'b0}}, clip_w} * {{COORD_W{1'b0}}, clip_h};
	assign area_sat = (area > (2*COORD_W)'(RUN_MAX)) ? RUN_MAX : area[COUNT_W-1:0];
	assign fill_ok = (size_w != '0) && (size_h != '0) &&
		(pos_x < panel_width_q) && (pos_y < panel_height_q);

	assign win_w = (s_tuser == REQ_FILL) ? clip_w : size_w;
	assign win_h = (s_tuser == REQ_FILL) ? clip_h : size_h;

	always_comb begin
		job.col_first = {7'b0, pos_x} + {7'b0, col_offset_q};
		job.col_final = job.col_first + {7'b0, win_w} - 16'd1;
		job.row_first = {7'b0, pos_y} + {7'b0, row_offset_q};
		job.row_final = job.row_first + {7'b0, win_h} - 16'd1;
		job.color     = pixel_color;
		job.run_len   = area_sat;
		job.rel_first = 1'b0;
		job.win       = 1'b0;
		job.run       = 1'b0;
		job.rel_last  = 1'b0;
		has_result    = 1'b0;
		open_nxt      = write_open_q;
		unique case (s_tuser)
			REQ_FILL: begin
				if (fill_ok) begin
					has_result    = 1'b1;
					job.rel_first = write_open_q;
					job.win       = 1'b1;
					job.run       = 1'b1;
					job.rel_last  = 1'b1;
					open_nxt      = 1'b0;
				end
			end
			REQ_BEGIN: begin
				if ((size_w != '0) && (size_h != '0)) begin
					has_result    = 1'b1;
					job.rel_first = write_open_q;
					job.win       = 1'b1;
					open_nxt      = 1'b1;
				end
			end
			REQ_PIXEL: begin
				has_result   = 1'b1;
				job.run      = 1'b1;
				job.rel_last = !write_open_q;
				job.run_len  = COUNT_W'(1);
			end
			REQ_RUN: begin
				if (pixel_count != '0) begin
					has_result   = 1'b1;
					job.run      = 1'b1;
					job.rel_last = !write_open_q;
					job.run_len  = pixel_count;
				end
			end
			REQ_END: begin
				if (write_open_q) begin
					has_result   = 1'b1;
					job.rel_last = 1'b1;
					open_nxt     = 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/lwfs_fifo.sv */
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module lwfs_fifo #(
	parameter int DEPTH = lwfs_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lwfs_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output lwfs_pkg::job_t head_job
);
	import lwfs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/lwfs_back.sv */
// Back end: steps through each queued job and drives the result register.
`timescale 1ns / 1ps
`include "lcd_window_fill_sequencer_macros.svh"

module lwfs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  lwfs_pkg::job_t               job,
	output logic                         job_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lwfs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [lwfs_pkg::KIND_W-1:0]    m_tuser,
	output logic                         m_tlast
);
	import lwfs_pkg::*;

	typedef enum logic [13:0] {
		ST_REL_FIRST = 14'b00000000000001,
		ST_CMD_COL   = 14'b00000000000010,
		ST_COL_FH    = 14'b00000000000100,
		ST_COL_FL    = 14'b00000000001000,
		ST_COL_LH    = 14'b00000000010000,
		ST_COL_LL    = 14'b00000000100000,
		ST_CMD_ROW   = 14'b00000001000000,
		ST_ROW_FH    = 14'b00000010000000,
		ST_ROW_FL    = 14'b00000100000000,
		ST_ROW_LH    = 14'b00001000000000,
		ST_ROW_LL    = 14'b00010000000000,
		ST_CMD_MEM   = 14'b00100000000000,
		ST_RUN       = 14'b01000000000000,
		ST_REL_LAST  = 14'b10000000000000
	} step_t;

	step_t               step_q, first_step, cur_step, nxt_step, tail_step;
	logic                started_q;
	logic                adv, cur_last, tail_any;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   data_byte;
	logic [COLOR_W-1:0]  run_color;
	logic [COUNT_W-1:0]  run_length;

	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [COLOR_W-1:0]  out_color_q;
	logic [COUNT_W-1:0]  out_len_q;
	logic                out_last_q;

	assign adv     = job_valid && (!out_valid_q || m_tready);
	assign job_pop = adv && cur_last;

	assign tail_step = job.run ? ST_RUN : ST_REL_LAST;
	assign tail_any  = job.run || job.rel_last;
	assign first_step = job.rel_first ? ST_REL_FIRST : (job.win ? ST_CMD_COL : tail_step);
	assign cur_step  = started_q ? step_q : first_step;

	always_comb begin
		kind       = KIND_DATA;
		data_byte  = '0;
		run_color  = '0;
		run_length = '0;
		nxt_step   = ST_REL_LAST;
		cur_last   = 1'b0;
		unique case (cur_step)
			ST_REL_FIRST: begin
				kind     = KIND_RELEASE;
				nxt_step = job.win ? ST_CMD_COL : tail_step;
				cur_last = !job.win && !tail_any;
			end
			ST_CMD_COL: begin
				kind      = KIND_CMD;
				data_byte = CMD_COLUMN_WINDOW;
				nxt_step  = ST_COL_FH;
			end
			ST_COL_FH: begin
				data_byte = job.col_first[15:8];
				nxt_step  = ST_COL_FL;
			end
			ST_COL_FL: begin
				data_byte = BYTE_W'(job.col_first & LOW_BYTE_MASK);
				nxt_step  = ST_COL_LH;
			end
			ST_COL_LH: begin
				data_byte = job.col_final[15:8];
				nxt_step  = ST_COL_LL;
			end
			ST_COL_LL: begin
				data_byte = BYTE_W'(job.col_final & LOW_BYTE_MASK);
				nxt_step  = ST_CMD_ROW;
			end
			ST_CMD_ROW: begin
				kind      = KIND_CMD;
				data_byte = CMD_ROW_WINDOW;
				nxt_step  = ST_ROW_FH;
			end
			ST_ROW_FH: begin
				data_byte = job.row_first[15:8];
				nxt_step  = ST_ROW_FL;
			end
			ST_ROW_FL: begin
				data_byte = BYTE_W'(job.row_first & LOW_BYTE_MASK);
				nxt_step  = ST_ROW_LH;
			end
			ST_ROW_LH: begin
				data_byte = job.row_final[15:8];
				nxt_step  = ST_ROW_LL;
			end
			ST_ROW_LL: begin
				data_byte = BYTE_W'(job.row_final & LOW_BYTE_MASK);
				nxt_step  = ST_CMD_MEM;
			end
			ST_CMD_MEM: begin
				kind      = KIND_CMD;
				data_byte = CMD_MEMORY_WRITE;
				nxt_step  = tail_step;
				cur_last  = !tail_any;
			end
			ST_RUN: begin
				kind       = KIND_RUN;
				run_color  = job.color;
				run_length = job.run_len;
				nxt_step   = ST_REL_LAST;
				cur_last   = !job.rel_last;
			end
			ST_REL_LAST: begin
				kind     = KIND_RELEASE;
				cur_last = 1'b1;
			end
			default: begin
				kind     = KIND_RELEASE;
				cur_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			step_q      <= ST_REL_LAST;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				started_q   <= !cur_last;
				step_q      <= nxt_step;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind_q  <= kind;
			out_byte_q  <= data_byte;
			out_color_q <= run_color;
			out_len_q   <= run_length;
			out_last_q  <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_len_q, out_color_q, out_byte_q};

	`LWFS_ASSERT_NOW(a_started_has_job, started_q, job_valid)
	`LWFS_ASSERT_NEXT(a_stalled_step_holds, started_q && !adv,
		started_q && (step_q == $past(step_q)))
	`LWFS_ASSERT_NEXT(a_unfinished_job_stays, adv && !cur_last, started_q)

endmodule

/* sv/lcd_window_fill_sequencer.sv */
// Top level of the panel window and fill sequencer.
//
// Requests enter on the s_ stream: s_tuser carries the request type, s_tdata
// the coordinates, sizes, color and run count. Results leave on the m_ stream,
// one per transfer: m_tuser is the result kind, m_tdata the byte, run color and
// run length, m_tlast marks the final result of a request.
// Panel size and offsets are written on cfg_we/cfg_index/cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it. A
// request is taken whenever the job queue has room and sits in the queue
// until the sequencer reaches it. Its first result passes through a queue slot
// and then the result register. The sequencer gives one result per cycle while
// the receiver takes them; a request has 1 to 14 results (pixel push inside an
// open write 1, standalone pixel push 2, fill up to 14). Requests with no
// result reach no queue slot.
// Reset closes any open pixel write, empties the queue and restores panel
// 240 x 320 with zero offsets. A stalled receiver holds the result register;
// requests still enter until the queue of FIFO_DEPTH jobs fills.
`timescale 1ns / 1ps

module lcd_window_fill_sequencer #(
	parameter int FIFO_DEPTH = lwfs_pkg::FIFO_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lwfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lwfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, size_w, size_h, pixel_color, pixel_count, zero pad
	input  logic [lwfs_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [lwfs_pkg::REQ_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// data_byte, run_color, run_length, zero pad
	output logic [lwfs_pkg::M_TDATA_W-1:0]  m_tdata,
	// kind
	output logic [lwfs_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	import lwfs_pkg::*;

	job_t front_job, head_job;
	logic job_push, job_full, job_valid, job_pop;

	lwfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (front_job)
	);

	lwfs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (front_job),
		.pop        (job_pop),
		.full       (job_full),
		.head_valid (job_valid),
		.head_job   (head_job)
	);

	lwfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
